FILE: sv/ibtm_pkg.sv
// Shared types, codes and constants of the IP ban table matcher.
package ibtm_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 32;
	localparam int unsigned MAX_RESULTS     = 32;
	localparam int unsigned RES_CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [31:0] UPPER_OCTETS   = 32'hffff_ff00;
	localparam logic [7:0]  LOOPBACK_OCTET = 8'd127;
	localparam logic [31:0] ADDR_ONES      = 32'hffff_ffff;

	typedef enum logic [2:0] {
		KIND_ADD        = 3'd0,
		KIND_REM_EXACT  = 3'd1,
		KIND_REM_STREAM = 3'd2,
		KIND_FIND_ANY   = 3'd3,
		KIND_FIND_EXACT = 3'd4,
		KIND_LIST       = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NOMATCH  = 3'd1,
		STAT_BADADDR  = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_LOOPBACK = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESP,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [7:0]  mask;
		logic [7:0]  stream;
	} entry_t;

	typedef struct packed {
		logic stream_eq;
		logic mask_eq;
		logic addr_eq;
		logic masked_hit;
	} cmp_t;

endpackage

FILE: sv/ibtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ibtm_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/ibtm_cmp.sv
// Shared compare unit: checks one stored entry against the current command.
module ibtm_cmp (
	input  ibtm_pkg::entry_t ent,
	input  logic [31:0]      ip_addr,
	input  logic [7:0]       mask,
	input  logic [7:0]       stream,
	output ibtm_pkg::cmp_t   res
);

	logic [31:0] full_mask;

	// The upper three octets always take part; the entry's mask trims the last one.
	assign full_mask = {24'd0, ent.mask} | ibtm_pkg::UPPER_OCTETS;

	assign res.stream_eq  = (ent.stream == stream);
	assign res.mask_eq    = (ent.mask == mask);
	assign res.addr_eq    = (ent.addr == ip_addr);
	assign res.masked_hit = ((ent.addr & full_mask) == (ip_addr & full_mask));

endmodule

FILE: sv/ip_ban_table_matcher.sv
// Top level of the IP ban table matcher: command sequencer over a packed entry table.
//
// Commands arrive on the input channel (in_valid/in_ready) and results leave on the
// output channel (out_valid/out_ready); every command ends with one result that has
// last set, and a list command gives one result per entry of its stream, at most 32.
// The block takes one command at a time and is not ready while it works on one.
// An add that is OK writes its entry at transfer, then gives its result. Remove, find and list
// walk the table through the single RAM read port, one entry per cycle, using the
// shared compare unit. A remove that hits then packs the table, one entry moved
// per cycle through the same port, starting where the walk stopped.
// Results sit in an output register; while the receiver stalls, a list walk waits
// whenever it needs to hand over a further result, and other commands hold their
// result until it is taken.
// Reset empties the table by clearing the entry count; the RAM itself is not
// cleared, since only entries below the count are ever read.
module ip_ban_table_matcher #(
	parameter int unsigned TABLE_DEPTH = ibtm_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] ip_addr,
	input  logic [7:0]  mask,
	input  logic [7:0]  stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] entry_addr,
	output logic [7:0]  entry_mask,
	output logic        last
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned NW = ibtm_pkg::RES_CNT_W;

	ibtm_pkg::state_t  state_q, state_d;
	ibtm_pkg::kind_t   kind_q;
	logic [31:0]       ip_q;
	logic [7:0]        mask_q;
	logic [7:0]        sid_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [NW-1:0]     nmatch_q;
	logic              pend_valid_q;
	ibtm_pkg::entry_t  pend_q;
	ibtm_pkg::status_t resp_st_q;

	logic              out_valid_q;
	ibtm_pkg::status_t status_q;
	logic [31:0]       entry_addr_q;
	logic [7:0]        entry_mask_q;
	logic              last_q;

	ibtm_pkg::entry_t  rdata;
	ibtm_pkg::entry_t  wdata;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	ibtm_pkg::cmp_t    cmp;

	logic              in_fire;
	logic              out_free;
	logic              hit;
	logic              scan_end;
	logic              shift_end;
	logic              list_cap;
	ibtm_pkg::kind_t   in_kind;
	ibtm_pkg::status_t add_st;

	// Sequencer actions
	logic              advance;
	logic              go_scan;
	logic              go_shift;
	logic              go_resp;
	logic              go_flush;
	logic              go_idle;
	ibtm_pkg::status_t resp_st_d;
	logic              cnt_inc;
	logic              cnt_dec;
	logic              take_pend;
	logic              out_load;
	ibtm_pkg::status_t out_st_d;
	logic [31:0]       out_addr_d;
	logic [7:0]        out_mask_d;
	logic              out_last_d;

	ibtm_ram #(
		.WIDTH($bits(ibtm_pkg::entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	ibtm_cmp u_cmp (
		.ent    (rdata),
		.ip_addr(ip_q),
		.mask   (mask_q),
		.stream (sid_q),
		.res    (cmp)
	);

	assign in_ready = (state_q == ibtm_pkg::S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_kind  = ibtm_pkg::kind_t'(kind);

	assign scan_end  = (CW'(idx_q) == (count_q - CW'(1)));
	assign shift_end = ((CW'(idx_q) + CW'(2)) == count_q);
	assign list_cap  = ((nmatch_q + NW'(1)) == NW'(ibtm_pkg::MAX_RESULTS));

	always_comb begin
		unique case (kind_q)
			ibtm_pkg::KIND_REM_EXACT:  hit = cmp.stream_eq && cmp.addr_eq && cmp.mask_eq;
			ibtm_pkg::KIND_FIND_ANY:   hit = cmp.stream_eq && cmp.masked_hit;
			ibtm_pkg::KIND_FIND_EXACT: hit = cmp.stream_eq && cmp.mask_eq && cmp.masked_hit;
			default:                   hit = cmp.stream_eq;
		endcase
	end

	// Loopback is tested before the bad-address check.
	always_comb begin
		priority if (ip_addr[31:24] == ibtm_pkg::LOOPBACK_OCTET) begin
			add_st = ibtm_pkg::STAT_LOOPBACK;
		end else if (ip_addr == 32'd0 || ip_addr == ibtm_pkg::ADDR_ONES) begin
			add_st = ibtm_pkg::STAT_BADADDR;
		end else if (count_q == CW'(TABLE_DEPTH)) begin
			add_st = ibtm_pkg::STAT_FULL;
		end else begin
			add_st = ibtm_pkg::STAT_OK;
		end
	end

	// Action decode
	always_comb begin
		advance    = 1'b0;
		go_scan    = 1'b0;
		go_shift   = 1'b0;
		go_resp    = 1'b0;
		go_flush   = 1'b0;
		go_idle    = 1'b0;
		resp_st_d  = ibtm_pkg::STAT_NOMATCH;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		take_pend  = 1'b0;
		out_load   = 1'b0;
		out_st_d   = ibtm_pkg::STAT_OK;
		out_addr_d = pend_q.addr;
		out_mask_d = pend_q.mask;
		out_last_d = 1'b0;
		we         = 1'b0;
		waddr      = idx_q;
		wdata      = rdata;
		raddr      = idx_q;
		unique case (state_q)
			ibtm_pkg::S_IDLE: begin
				raddr = '0;
				waddr = count_q[AW-1:0];
				wdata = '{addr: ip_addr, mask: mask, stream: stream};
				if (in_fire) begin
					unique case (in_kind)
						ibtm_pkg::KIND_ADD: begin
							go_resp   = 1'b1;
							resp_st_d = add_st;
							if (add_st == ibtm_pkg::STAT_OK) begin
								we      = 1'b1;
								cnt_inc = 1'b1;
							end
						end
						ibtm_pkg::KIND_REM_EXACT, ibtm_pkg::KIND_REM_STREAM,
						ibtm_pkg::KIND_FIND_ANY, ibtm_pkg::KIND_FIND_EXACT,
						ibtm_pkg::KIND_LIST: begin
							if (count_q == '0) begin
								go_resp = 1'b1;
							end else begin
								go_scan = 1'b1;
							end
						end
						default: go_resp = 1'b1;
					endcase
				end
			end
			ibtm_pkg::S_SCAN: begin
				unique case (kind_q)
					ibtm_pkg::KIND_REM_EXACT, ibtm_pkg::KIND_REM_STREAM: begin
						if (hit) begin
							resp_st_d = ibtm_pkg::STAT_OK;
							if (scan_end) begin
								cnt_dec = 1'b1;
								go_resp = 1'b1;
							end else begin
								go_shift = 1'b1;
								raddr    = AW'(CW'(idx_q) + CW'(1));
							end
						end else if (scan_end) begin
							go_resp = 1'b1;
						end else begin
							advance = 1'b1;
						end
					end
					ibtm_pkg::KIND_LIST: begin
						if (hit) begin
							// A held match goes out only once a newer one shows it is not last.
							if (!pend_valid_q || out_free) begin
								out_load  = pend_valid_q;
								take_pend = 1'b1;
								if (list_cap || scan_end) begin
									go_flush = 1'b1;
								end else begin
									advance = 1'b1;
								end
							end
						end else if (scan_end) begin
							if (pend_valid_q) begin
								go_flush = 1'b1;
							end else begin
								go_resp = 1'b1;
							end
						end else begin
							advance = 1'b1;
						end
					end
					default: begin
						if (hit) begin
							resp_st_d = ibtm_pkg::STAT_OK;
							go_resp   = 1'b1;
						end else if (scan_end) begin
							go_resp = 1'b1;
						end else begin
							advance = 1'b1;
						end
					end
				endcase
				if (advance) begin
					raddr = AW'(CW'(idx_q) + CW'(1));
				end
			end
			ibtm_pkg::S_SHIFT: begin
				// Read data holds the entry above idx_q; move it down one place.
				we    = 1'b1;
				raddr = AW'(CW'(idx_q) + CW'(2));
				if (shift_end) begin
					cnt_dec   = 1'b1;
					go_resp   = 1'b1;
					resp_st_d = ibtm_pkg::STAT_OK;
				end else begin
					advance = 1'b1;
				end
			end
			ibtm_pkg::S_RESP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_st_d   = resp_st_q;
					out_addr_d = '0;
					out_mask_d = '0;
					out_last_d = 1'b1;
					go_idle    = 1'b1;
				end
			end
			ibtm_pkg::S_FLUSH: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					go_idle    = 1'b1;
				end
			end
			default: go_idle = 1'b1;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		priority if (go_idle) begin
			state_d = ibtm_pkg::S_IDLE;
		end else if (go_scan) begin
			state_d = ibtm_pkg::S_SCAN;
		end else if (go_shift) begin
			state_d = ibtm_pkg::S_SHIFT;
		end else if (go_resp) begin
			state_d = ibtm_pkg::S_RESP;
		end else if (go_flush) begin
			state_d = ibtm_pkg::S_FLUSH;
		end else begin
			state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ibtm_pkg::S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			nmatch_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (go_scan) begin
				idx_q        <= '0;
				nmatch_q     <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				if (advance) begin
					idx_q <= idx_q + AW'(1);
				end
				if (take_pend) begin
					nmatch_q     <= nmatch_q + NW'(1);
					pend_valid_q <= 1'b1;
				end else if (state_q == ibtm_pkg::S_FLUSH && out_free) begin
					pend_valid_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= in_kind;
			ip_q   <= ip_addr;
			mask_q <= mask;
			sid_q  <= stream;
		end
		if (go_resp) begin
			resp_st_q <= resp_st_d;
		end
		if (take_pend) begin
			pend_q <= rdata;
		end
		if (out_load) begin
			status_q     <= out_st_d;
			entry_addr_q <= out_addr_d;
			entry_mask_q <= out_mask_d;
			last_q       <= out_last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign entry_addr = entry_addr_q;
	assign entry_mask = entry_mask_q;
	assign last       = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ibtm_pkg::S_SCAN || state_q == ibtm_pkg::S_SHIFT) |-> count_q != '0)
		else $error("table walk on an empty table");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("ready straight after an input transfer");

	a_flush_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ibtm_pkg::S_FLUSH |-> pend_valid_q)
		else $error("list flush without a held entry");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nmatch_q <= NW'(ibtm_pkg::MAX_RESULTS))
		else $error("list result count beyond limit");

endmodule

FILE: tb/ip_ban_table_matcher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IP ban table matcher, with its own table predictor.
module ip_ban_table_matcher_tb;

	localparam int CLK_PERIOD      = 12;
	localparam int TBL_DEPTH       = ibtm_pkg::TABLE_DEPTH_DEF;
	localparam int RANDOM_ITEMS    = 350;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES   = 2 * TBL_DEPTH + 10;

	// Command codes that the block has no use for.
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] addr;
		logic [7:0]  mask;
		logic [7:0]  stream;
	} ban_cmd_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] addr;
		logic [7:0]  msk;
		logic        fin;
	} ban_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind;
	logic [31:0] ip_addr;
	logic [7:0]  mask;
	logic [7:0]  stream;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] entry_addr;
	logic [7:0]  entry_mask;
	logic        last;

	ban_cmd_t   cur_cmd = '0;
	ban_cmd_t   cmd_pending[$];
	ban_reply_t expected_replies[$];

	// Predicted table contents.
	ibtm_pkg::entry_t tbl_entry[TBL_DEPTH];
	int               tbl_count = 0;

	int cycle_count = 0;
	int fail_count = 0;
	int cmds_queued = 0;
	int cmds_accepted = 0;
	int replies_checked = 0;
	int longest_list = 0;
	int status_tally[8] = '{default: 0};
	int idle_left = 0;
	int burst_left = 1;
	int hold_off_orders = 0;
	int hold_off_served = 0;
	int hold_left = 0;
	int ready_mode = 0;
	int mode_left = 0;

	assign kind    = cur_cmd.kind;
	assign ip_addr = cur_cmd.addr;
	assign mask    = cur_cmd.mask;
	assign stream  = cur_cmd.stream;

	ip_ban_table_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.ip_addr(ip_addr),
		.mask(mask),
		.stream(stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_addr(entry_addr),
		.entry_mask(entry_mask),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Appends one reply to the tail of the expected queue.
	task automatic expect_reply(input ban_reply_t r);
		expected_replies.insert(expected_replies.size(), r);
	endtask

	// Applies one command to the predicted table and queues the replies it should give.
	task automatic apply_ban_command(input ban_cmd_t c);
		int         i;
		int         j;
		int         pos;
		int         hits;
		logic [31:0] m;
		logic [2:0]  st;
		ban_reply_t held;
		st = ibtm_pkg::STAT_NOMATCH;
		pos = -1;
		hits = 0;
		held = '0;
		case (c.kind)
			ibtm_pkg::KIND_ADD: begin
				if (c.addr[31:24] == ibtm_pkg::LOOPBACK_OCTET) begin
					st = ibtm_pkg::STAT_LOOPBACK;
				end else if (c.addr == 32'd0 || c.addr == ibtm_pkg::ADDR_ONES) begin
					st = ibtm_pkg::STAT_BADADDR;
				end else if (tbl_count >= TBL_DEPTH) begin
					st = ibtm_pkg::STAT_FULL;
				end else begin
					tbl_entry[tbl_count] = '{addr: c.addr, mask: c.mask, stream: c.stream};
					tbl_count++;
					st = ibtm_pkg::STAT_OK;
				end
			end
			ibtm_pkg::KIND_REM_EXACT, ibtm_pkg::KIND_REM_STREAM: begin
				for (i = 0; i < tbl_count && pos < 0; i++) begin
					if (tbl_entry[i].stream == c.stream &&
							(c.kind == ibtm_pkg::KIND_REM_STREAM ||
							(tbl_entry[i].addr == c.addr && tbl_entry[i].mask == c.mask)))
						pos = i;
				end
				if (pos >= 0) begin
					// The table stays packed, so later entries move down one place.
					for (j = pos; j < tbl_count - 1; j++)
						tbl_entry[j] = tbl_entry[j + 1];
					tbl_count--;
					st = ibtm_pkg::STAT_OK;
				end
			end
			ibtm_pkg::KIND_FIND_ANY, ibtm_pkg::KIND_FIND_EXACT: begin
				for (i = 0; i < tbl_count; i++) begin
					m = ibtm_pkg::UPPER_OCTETS | {24'd0, tbl_entry[i].mask};
					if (tbl_entry[i].stream == c.stream &&
							(c.kind == ibtm_pkg::KIND_FIND_ANY ||
							tbl_entry[i].mask == c.mask) &&
							((tbl_entry[i].addr & m) == (c.addr & m)))
						st = ibtm_pkg::STAT_OK;
				end
			end
			ibtm_pkg::KIND_LIST: begin
				for (i = 0; i < tbl_count && hits < ibtm_pkg::MAX_RESULTS; i++) begin
					if (tbl_entry[i].stream == c.stream) begin
						if (hits > 0)
							expect_reply(held);
						held = '{st: ibtm_pkg::STAT_OK, addr: tbl_entry[i].addr,
							msk: tbl_entry[i].mask, fin: 1'b0};
						hits++;
					end
				end
				if (hits > longest_list)
					longest_list = hits;
				if (hits == 0) begin
					held = '{st: ibtm_pkg::STAT_NOMATCH, addr: 32'd0, msk: 8'd0, fin: 1'b1};
				end else begin
					held.fin = 1'b1;
				end
				expect_reply(held);
			end
			default: st = ibtm_pkg::STAT_NOMATCH;
		endcase
		if (c.kind != ibtm_pkg::KIND_LIST)
			expect_reply(ban_reply_t'{st: st, addr: 32'd0, msk: 8'd0, fin: 1'b1});
	endtask

	// Sender: bursts of transfers with random gaps in between.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cur_cmd <= '0;
			idle_left <= 0;
			burst_left <= 1;
		end else begin
			if (in_valid && in_ready) begin
				apply_ban_command(cur_cmd);
				cmds_accepted <= cmds_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					in_valid <= 1'b0;
				end else if (cmd_pending.size() > 0) begin
					cur_cmd <= cmd_pending.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						idle_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each transfer and stalls on a mode that changes now and then.
	always @(posedge clk or negedge arst_n) begin
		ban_reply_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			mode_left <= 0;
			ready_mode <= 0;
		end else begin
			if (out_valid && out_ready) begin
				replies_checked <= replies_checked + 1;
				status_tally[status] <= status_tally[status] + 1;
				if (expected_replies.size() == 0) begin
					$error("unexpected result: status %0d, entry_addr %h, entry_mask %h, last %0d",
						status, entry_addr, entry_mask, last);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.st ||
							entry_addr !== want.addr ||
							entry_mask !== want.msk ||
							last !== want.fin)
						fail_count <= fail_count + 1;
					if (status !== want.st)
						$error("status: expected %0d, got %0d", want.st, status);
					if (entry_addr !== want.addr)
						$error("entry_addr: expected %h, got %h", want.addr, entry_addr);
					if (entry_mask !== want.msk)
						$error("entry_mask: expected %h, got %h", want.msk, entry_mask);
					if (last !== want.fin)
						$error("last: expected %0d, got %0d", want.fin, last);
				end
			end
			if (hold_off_orders != hold_off_served) begin
				hold_off_served <= hold_off_orders;
				hold_left <= HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode <= $urandom_range(0, 2);
					mode_left <= $urandom_range(40, 160);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (ready_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 7);
					default: out_ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d results outstanding",
			cycle_count, expected_replies.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic queue_cmd(input logic [2:0] k, input logic [31:0] a,
			input logic [7:0] m, input logic [7:0] s);
		cmd_pending.insert(cmd_pending.size(),
			ban_cmd_t'{kind: k, addr: a, mask: m, stream: s});
		cmds_queued++;
	endtask

	// Waits until every transfer has gone through and every result has come.
	task automatic wait_for_quiet();
		while (cmd_pending.size() != 0 || in_valid || expected_replies.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] rand_host_addr();
		logic [31:0] a;
		a = $urandom;
		if (a[31:24] == ibtm_pkg::LOOPBACK_OCTET || a == 32'd0 || a == ibtm_pkg::ADDR_ONES)
			a[30] = ~a[30];
		return a;
	endfunction

	initial begin : stimulus
		logic [31:0]      addr_pool[8];
		logic [7:0]       stream_pool[4];
		ban_cmd_t         recent_adds[$];
		ban_cmd_t         pick;
		ibtm_pkg::entry_t snap[TBL_DEPTH];
		int               snap_count;
		int               n;
		int               i;
		int               rand_target;
		int               next_pause;
		bit               full_done;
		logic [7:0]       s;
		logic [31:0]      a;

		for (i = 0; i < 8; i++)
			addr_pool[i] = rand_host_addr();
		stream_pool[0] = 8'h00;
		for (i = 1; i < 4; i++)
			stream_pool[i] = 8'($urandom_range(1, 255));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: address extremes, loopback, duplicates, masked matches and every kind.
		queue_cmd(ibtm_pkg::KIND_ADD, 32'h0000_0000, 8'h00, 8'h00);
		queue_cmd(ibtm_pkg::KIND_ADD, ibtm_pkg::ADDR_ONES, 8'hFF, 8'hFF);
		queue_cmd(ibtm_pkg::KIND_ADD, 32'h7F00_0001, 8'h00, 8'h00);
		queue_cmd(ibtm_pkg::KIND_ADD, 32'h7FFF_FFFF, 8'hFF, 8'h01);
		queue_cmd(ibtm_pkg::KIND_ADD, 32'h0000_0001, 8'hF0, 8'h00);
		queue_cmd(ibtm_pkg::KIND_ADD, 32'hFFFF_FFFE, 8'h0F, 8'h01);
		queue_cmd(ibtm_pkg::KIND_ADD, 32'h8000_0000, 8'hFF, 8'hFF);
		queue_cmd(ibtm_pkg::KIND_ADD, 32'h8000_0000, 8'hFF, 8'hFF);
		queue_cmd(ibtm_pkg::KIND_ADD, 32'h0A0B_0C0D, 8'h00, 8'h01);
		queue_cmd(ibtm_pkg::KIND_FIND_ANY, 32'hFFFF_FF1E, 8'h00, 8'h01);
		queue_cmd(ibtm_pkg::KIND_FIND_ANY, 32'h0A0B_0CEE, 8'h5A, 8'h01);
		queue_cmd(ibtm_pkg::KIND_FIND_ANY, 32'h0A0B_0DEE, 8'h00, 8'h01);
		queue_cmd(ibtm_pkg::KIND_FIND_EXACT, 32'hFFFF_FFFE, 8'h0F, 8'h01);
		queue_cmd(ibtm_pkg::KIND_FIND_EXACT, 32'hFFFF_FFFE, 8'hFF, 8'h01);
		queue_cmd(ibtm_pkg::KIND_FIND_ANY, 32'h0000_0001, 8'hF0, 8'h02);
		queue_cmd(ibtm_pkg::KIND_LIST, 32'h0000_0000, 8'h00, 8'hFF);
		queue_cmd(ibtm_pkg::KIND_LIST, 32'h0000_0000, 8'h00, 8'h07);
		queue_cmd(ibtm_pkg::KIND_REM_EXACT, 32'h8000_0000, 8'hFE, 8'hFF);
		queue_cmd(ibtm_pkg::KIND_REM_EXACT, 32'h8000_0000, 8'hFF, 8'hFF);
		queue_cmd(ibtm_pkg::KIND_REM_STREAM, 32'h1234_5678, 8'hAA, 8'h01);
		queue_cmd(ibtm_pkg::KIND_REM_STREAM, 32'h0000_0000, 8'h00, 8'h42);
		queue_cmd(ibtm_pkg::KIND_LIST, 32'h0000_0000, 8'h00, 8'h01);
		queue_cmd(KIND_SPARE_LO, 32'h0000_0000, 8'h00, 8'h00);
		queue_cmd(KIND_SPARE_HI, ibtm_pkg::ADDR_ONES, 8'hFF, 8'hFF);
		wait_for_quiet();

		rand_target = cmds_queued + RANDOM_ITEMS;
		next_pause = cmds_queued + 90;
		full_done = 1'b0;
		while (cmds_queued < rand_target) begin
			if (cmds_queued >= next_pause) begin
				wait_for_quiet();
				next_pause = cmds_queued + $urandom_range(60, 120);
			end
			if (!full_done && cmds_queued >= rand_target - 200) begin
				// Empty the table, fill one stream past the top, then list it with
				// the receiver held off so that the block backs up.
				wait_for_quiet();
				snap_count = tbl_count;
				for (i = 0; i < snap_count; i++)
					snap[i] = tbl_entry[i];
				for (i = 0; i < snap_count; i++)
					queue_cmd(ibtm_pkg::KIND_REM_EXACT, snap[i].addr, snap[i].mask,
						snap[i].stream);
				s = 8'($urandom_range(1, 255));
				for (i = 0; i < TBL_DEPTH + 2; i++)
					queue_cmd(ibtm_pkg::KIND_ADD, rand_host_addr(),
						8'($urandom_range(0, 255)), s);
				wait_for_quiet();
				hold_off_orders++;
				queue_cmd(ibtm_pkg::KIND_LIST, 32'd0, 8'd0, s);
				for (i = 0; i < 6; i++)
					queue_cmd(ibtm_pkg::KIND_FIND_ANY, rand_host_addr(), 8'd0, s);
				queue_cmd(ibtm_pkg::KIND_LIST, 32'd0, 8'd0, s ^ 8'h01);
				for (i = 0; i < 5; i++)
					queue_cmd(ibtm_pkg::KIND_REM_STREAM, 32'd0, 8'd0, s);
				full_done = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(1, 4);
					for (i = 0; i < n; i++) begin
						a = ($urandom_range(0, 2) == 0) ? rand_host_addr()
							: addr_pool[$urandom_range(0, 7)];
						pick = '{kind: ibtm_pkg::KIND_ADD, addr: a,
							mask: 8'($urandom_range(0, 255)),
							stream: stream_pool[$urandom_range(0, 3)]};
						queue_cmd(pick.kind, pick.addr, pick.mask, pick.stream);
						recent_adds.insert(recent_adds.size(), pick);
						if (recent_adds.size() > 16)
							void'(recent_adds.pop_front());
					end
					queue_cmd(ibtm_pkg::KIND_FIND_ANY,
						pick.addr ^ {24'd0, 8'($urandom) & ~pick.mask},
						8'($urandom_range(0, 255)), pick.stream);
				end
				3: begin
					if (recent_adds.size() > 0) begin
						pick = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
						a = pick.addr ^ {24'd0, 8'($urandom) & ~pick.mask};
						if ($urandom_range(0, 3) == 0)
							a[$urandom_range(8, 31)] ^= 1'b1;
						queue_cmd(ibtm_pkg::KIND_FIND_EXACT, a,
							($urandom_range(0, 3) == 0) ? 8'($urandom) : pick.mask,
							pick.stream);
					end
				end
				4: begin
					if (recent_adds.size() > 0) begin
						pick = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
						queue_cmd(ibtm_pkg::KIND_REM_EXACT, pick.addr, pick.mask, pick.stream);
					end
				end
				5: queue_cmd(ibtm_pkg::KIND_REM_STREAM, $urandom, 8'($urandom_range(0, 255)),
					stream_pool[$urandom_range(0, 3)]);
				6: queue_cmd(ibtm_pkg::KIND_LIST, 32'd0, 8'd0,
					stream_pool[$urandom_range(0, 3)]);
				7: begin
					case ($urandom_range(0, 2))
						0: a = {ibtm_pkg::LOOPBACK_OCTET, 24'($urandom)};
						1: a = 32'd0;
						default: a = ibtm_pkg::ADDR_ONES;
					endcase
					queue_cmd(ibtm_pkg::KIND_ADD, a, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
				8: queue_cmd(3'($urandom_range(0, 7)), $urandom, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				default: begin
					n = $urandom_range(3, 8);
					for (i = 0; i < n; i++)
						queue_cmd(ibtm_pkg::KIND_REM_STREAM, 32'd0, 8'd0,
							stream_pool[$urandom_range(0, 3)]);
					queue_cmd(ibtm_pkg::KIND_LIST, 32'd0, 8'd0,
						stream_pool[$urandom_range(0, 3)]);
				end
			endcase
		end

		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d commands and checked %0d results; longest list %0d entries.",
			cmds_accepted, replies_checked, longest_list);
		$display("Statuses seen: ok %0d, no match %0d, bad address %0d, full %0d, loopback %0d.",
			status_tally[ibtm_pkg::STAT_OK], status_tally[ibtm_pkg::STAT_NOMATCH],
			status_tally[ibtm_pkg::STAT_BADADDR], status_tally[ibtm_pkg::STAT_FULL],
			status_tally[ibtm_pkg::STAT_LOOPBACK]);
		if (fail_count == 0 && expected_replies.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
